// ===== design/ccws_pkg.sv =====
// Shared constants, types and helper functions of the coiled-coil window scorer.
`timescale 1ns / 1ps
package ccws_pkg;

  localparam int WINDOW       = 28;
  localparam int PHASES       = 7;
  localparam int ALPHABET_DEF = 26;
  localparam int VALUE_BITS   = 16;
  localparam int SUM_BITS     = 21;
  localparam int RES_BITS     = 5;
  localparam int PHASE_BITS   = 3;
  localparam int POS_BITS     = 16;
  localparam int OFF_BITS     = 5;
  localparam int COUNT_BITS   = 17;
  localparam int S_DATA_W     = 32;
  localparam int M_DATA_W     = 48;
  localparam int QUEUE_DEPTH  = 4;

  typedef enum logic {
    K_TABLE = 1'b0,
    K_RES   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_SEARCH,
    B_EMIT,
    B_SHORT
  } bstate_t;

  typedef struct packed {
    kind_t                         kind;
    logic                          wr_ok;
    logic [PHASE_BITS-1:0]         phase;
    logic [RES_BITS-1:0]           tres;
    logic signed [VALUE_BITS-1:0]  value;
    logic [RES_BITS-1:0]           res;
    logic                          last;
  } item_t;

  function automatic logic [PHASE_BITS-1:0] inc7(input logic [PHASE_BITS-1:0] x);
    return (x == PHASE_BITS'(PHASES - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [PHASE_BITS-1:0] dec7(input logic [PHASE_BITS-1:0] x);
    return (x == '0) ? PHASE_BITS'(PHASES - 1) : x - 1'b1;
  endfunction

  function automatic logic [PHASE_BITS-1:0] neg7(input logic [PHASE_BITS-1:0] x);
    return (x == '0) ? '0 : PHASE_BITS'(PHASES) - x;
  endfunction

  function automatic logic [OFF_BITS-1:0] incw(input logic [OFF_BITS-1:0] x);
    return (x == OFF_BITS'(WINDOW - 1)) ? '0 : x + 1'b1;
  endfunction

endpackage

// ===== design/ccws_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module ccws_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ccws_front.sv =====
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module ccws_front #(
  parameter int ALPHABET = ccws_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ccws_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  output logic                          q_valid,
  output ccws_pkg::item_t               q_item,
  input  logic                          pop
);
  import ccws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     fill;
  item_t              incoming;
  logic               push;

  always_comb begin
    incoming.kind  = kind_t'(s_tuser);
    incoming.phase = s_tdata[2:0];
    incoming.tres  = s_tdata[7:3];
    incoming.value = s_tdata[23:8];
    incoming.res   = s_tdata[28:24];
    incoming.last  = s_tlast;
    incoming.wr_ok = (s_tdata[2:0] < PHASE_BITS'(PHASES)) &&
                     ({1'b0, s_tdata[7:3]} < (RES_BITS + 1)'(ALPHABET));
  end

  assign s_tready = (fill != (PTR_W + 1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== design/ccws_back.sv =====
// Back end: table writes, window phase sums, covering-best search and result register.
`timescale 1ns / 1ps
module ccws_back #(
  parameter int ALPHABET = ccws_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ccws_pkg::item_t               q_item,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ccws_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import ccws_pkg::*;

  localparam int TDEPTH = PHASES * ALPHABET;
  localparam int TA_W   = $clog2(TDEPTH);
  localparam int SDEPTH = WINDOW * PHASES;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam logic [PHASE_BITS-1:0] DM_TOP = PHASE_BITS'((WINDOW - 1) % PHASES);

  bstate_t st, st_next;

  logic [RES_BITS-1:0]   rw [WINDOW];
  logic [WINDOW-1:0]     valid;
  logic [COUNT_BITS-1:0] count, q;
  logic [OFF_BITS-1:0]   head, newest;
  logic                  cur_last;

  logic [PHASE_BITS-1:0] h, ph;
  logic [OFF_BITS:0]     j;
  logic [OFF_BITS-1:0]   idx;
  logic signed [SUM_BITS-1:0] acc;
  logic                  rd_pend, rd_zero;

  logic [OFF_BITS-1:0]   e, d, slot, p;
  logic [PHASE_BITS-1:0] dm, k, hh;
  logic                  sdone, p_valid, p_ok, have;
  logic [OFF_BITS-1:0]   p_d;
  logic [PHASE_BITS-1:0] p_k;
  logic signed [SUM_BITS-1:0] bs;
  logic [PHASE_BITS-1:0] bk;
  logic [OFF_BITS-1:0]   bd;

  logic tbl_we, res_in, sum_rd, sum_wr, s_rd, emit, clr, out_free, sum_done, short_done;
  logic [TA_W-1:0]            taddr;
  logic [VALUE_BITS-1:0]      tdata_rd;
  logic [SA_W-1:0]            swaddr, sraddr;
  logic [SUM_BITS-1:0]        sdata_rd;
  logic [RES_BITS-1:0]        res_sel;
  logic [OFF_BITS-1:0]        e_setup;
  logic [OFF_BITS:0]          slot_sum;
  logic [PHASE_BITS-1:0]      dm_dec;
  logic [COUNT_BITS:0]        pos_wide;
  logic [POS_BITS-1:0]        pos_sat;

  assign out_free   = !m_tvalid || m_tready;
  assign sum_done   = (j == (OFF_BITS + 1)'(WINDOW)) && !rd_pend;
  assign short_done = (COUNT_BITS'(p) == q);
  assign res_sel    = rw[idx];

  always_comb begin
    st_next = st;
    case (st)
      B_IDLE: begin
        if (q_valid && q_item.kind == K_RES) begin
          if (count < COUNT_BITS'(WINDOW - 1)) begin
            st_next = q_item.last ? B_SHORT : B_IDLE;
          end else begin
            st_next = B_SUM;
          end
        end
      end
      B_SUM: begin
        if (sum_done && h == PHASE_BITS'(PHASES - 1)) begin
          st_next = B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (sdone && !p_valid) begin
          st_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          st_next = (cur_last && e != OFF_BITS'(WINDOW - 1)) ? B_SEARCH : B_IDLE;
        end
      end
      B_SHORT: begin
        if (out_free && short_done) begin
          st_next = B_IDLE;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop    = (st == B_IDLE) && q_valid;
    tbl_we = pop && q_item.kind == K_TABLE && q_item.wr_ok;
    res_in = pop && q_item.kind == K_RES;
    sum_rd = (st == B_SUM) && (j != (OFF_BITS + 1)'(WINDOW));
    sum_wr = (st == B_SUM) && sum_done;
    s_rd   = (st == B_SEARCH) && !sdone;
    emit   = ((st == B_EMIT) || (st == B_SHORT)) && out_free;
    clr    = emit && (((st == B_EMIT) && cur_last && e == OFF_BITS'(WINDOW - 1)) ||
                      ((st == B_SHORT) && short_done));
  end

  always_comb begin
    if (tbl_we) begin
      taddr = TA_W'(q_item.phase) * TA_W'(ALPHABET) + TA_W'(q_item.tres);
    end else begin
      taddr = TA_W'(ph) * TA_W'(ALPHABET) + TA_W'(res_sel);
    end
    swaddr   = SA_W'(newest) * SA_W'(PHASES) + SA_W'(h);
    sraddr   = SA_W'(slot) * SA_W'(PHASES) + SA_W'(hh);
    e_setup  = (st == B_EMIT) ? e + 1'b1 : '0;
    slot_sum = (OFF_BITS + 1)'(newest) + (OFF_BITS + 1)'(e_setup) + 1'b1;
    if (slot_sum >= (OFF_BITS + 1)'(WINDOW)) begin
      slot_sum = slot_sum - (OFF_BITS + 1)'(WINDOW);
    end
    dm_dec   = dec7(dm);
    pos_wide = (COUNT_BITS + 1)'(q) + (COUNT_BITS + 1)'(e) - (COUNT_BITS + 1)'(WINDOW - 1);
    pos_sat  = (pos_wide > (COUNT_BITS + 1)'(16'hFFFF)) ? '1 : pos_wide[POS_BITS-1:0];
  end

  ccws_ram #(.WIDTH(VALUE_BITS), .DEPTH(TDEPTH)) u_table (
    .clk(clk), .we(tbl_we), .waddr(taddr), .wdata(q_item.value),
    .raddr(taddr), .rdata(tdata_rd)
  );

  ccws_ram #(.WIDTH(SUM_BITS), .DEPTH(SDEPTH)) u_sums (
    .clk(clk), .we(sum_wr), .waddr(swaddr), .wdata(acc),
    .raddr(sraddr), .rdata(sdata_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < WINDOW; i++) begin
        rw[i] <= '0;
      end
      valid  <= '0;
      count  <= '0;
      head   <= '0;
      newest <= OFF_BITS'(WINDOW - 1);
    end else if (res_in) begin
      rw[head] <= q_item.res;
      head     <= incw(head);
      if (count != '1) begin
        count <= count + 1'b1;
      end
      if (count >= COUNT_BITS'(WINDOW - 1)) begin
        newest        <= incw(newest);
        valid[incw(newest)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_in) begin
      q        <= count;
      cur_last <= q_item.last;
      h        <= '0;
      j        <= '0;
      ph       <= '0;
      idx      <= incw(head);
      acc      <= '0;
      p        <= '0;
    end
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= sum_rd;
    end
    rd_zero <= ({1'b0, res_sel} >= (RES_BITS + 1)'(ALPHABET));
    if (sum_rd) begin
      j   <= j + 1'b1;
      ph  <= inc7(ph);
      idx <= incw(idx);
    end
    if (rd_pend && !rd_zero) begin
      acc <= acc + SUM_BITS'(signed'(tdata_rd));
    end
    if (sum_wr) begin
      h   <= inc7(h);
      j   <= '0;
      ph  <= inc7(h);
      idx <= head;
      acc <= '0;
    end
    if (sum_wr || (emit && st == B_EMIT)) begin
      e     <= e_setup;
      d     <= OFF_BITS'(WINDOW - 1);
      dm    <= DM_TOP;
      k     <= '0;
      hh    <= neg7(DM_TOP);
      slot  <= slot_sum[OFF_BITS-1:0];
      sdone <= 1'b0;
      have  <= 1'b0;
    end
    if (s_rd) begin
      if (k == PHASE_BITS'(PHASES - 1)) begin
        k <= '0;
        if (d == e) begin
          sdone <= 1'b1;
        end else begin
          d    <= d - 1'b1;
          dm   <= dm_dec;
          hh   <= neg7(dm_dec);
          slot <= incw(slot);
        end
      end else begin
        k  <= k + 1'b1;
        hh <= inc7(hh);
      end
    end
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= s_rd;
    end
    p_ok <= valid[slot];
    p_d  <= d;
    p_k  <= k;
    if (p_valid && p_ok && (!have || signed'(sdata_rd) > bs)) begin
      have <= 1'b1;
      bs   <= signed'(sdata_rd);
      bk   <= p_k;
      bd   <= p_d;
    end
    if (emit && st == B_SHORT) begin
      p <= p + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (st == B_SHORT) begin
        m_tdata <= {3'b000, OFF_BITS'(0), PHASE_BITS'(0), SUM_BITS'(0), POS_BITS'(p)};
        m_tuser <= 1'b1;
        m_tlast <= short_done;
      end else begin
        m_tdata <= {3'b000, bd, bk, bs, pos_sat};
        m_tuser <= 1'b0;
        m_tlast <= cur_last && e == OFF_BITS'(WINDOW - 1);
      end
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== design/coiled_coil_window_scorer_top.sv =====
// Top level of the coiled-coil window scorer.
// Input channel s_*: one word per table entry write (s_tuser 0) or residue (s_tuser 1).
// s_tlast marks the final residue of a sequence and flushes the remaining results.
// The score table must be loaded before residues arrive; it survives the end of a sequence.
// Output channel m_*: one word per residue, lagging the input by 27 residues.
// A residue with a full window first forms the seven phase sums through the single
// table port, then searches the window sum memory through its one read port for
// each result, e being the offset of that result from the newest window.
// A four-word queue between front and back keeps the input accepting while the
// back end works; when it fills, s_tready falls.
// A stalled receiver holds the result register and the back end waits with it.
// Reset clears the sequence state and the queue; the table is left undefined.
`timescale 1ns / 1ps
module coiled_coil_window_scorer_top #(
  parameter int ALPHABET = ccws_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // table_phase[2:0], table_residue[7:3], table_value[23:8], residue[28:24], zeros
  input  logic [ccws_pkg::S_DATA_W-1:0] s_tdata,
  // op
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // position[15:0], best_score[36:16], best_heptad[39:37], window_offset[44:40], zeros
  output logic [ccws_pkg::M_DATA_W-1:0] m_tdata,
  // short_sequence
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import ccws_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  pop;

  ccws_front #(.ALPHABET(ALPHABET)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast), .q_valid(q_valid), .q_item(q_item), .pop(pop)
  );

  ccws_back #(.ALPHABET(ALPHABET)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule

// ===== design/ccws_checker.sv =====
// Port-level checker for the coiled-coil window scorer, bound to the top level.
`timescale 1ns / 1ps
module ccws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [ccws_pkg::S_DATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ccws_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[44:16] == 29'd0)
    else $error("short-sequence result carries a score");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:37] != 3'd7 && m_tdata[44:40] < 5'd28)
    else $error("heptad or offset out of range");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind coiled_coil_window_scorer_top ccws_checker u_ccws_checker (.*);
